[hw/rtl/deq_pkg.sv]
`default_nettype none

package deq_pkg;

  localparam int DEPTH       = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(DEPTH + 1);

  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_BACK   = 3'd3;
  localparam logic [2:0] REQ_DUMP       = 3'd4;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [2:0] {
    OP_HOLD       = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4,
    OP_ROTATE     = 3'd5
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_t;

  typedef logic [VALUE_WIDTH-1:0] value_t;

  // Sign extension or truncation between the 32-bit ports and the stored width.
  function automatic value_t from_port(input logic [31:0] x);
    value_t v;
    for (int b = 0; b < VALUE_WIDTH; b++) begin
      v[b] = x[(b < 32) ? b : 31];
    end
    return v;
  endfunction

  function automatic logic [31:0] to_port(input value_t x);
    logic [31:0] v;
    for (int b = 0; b < 32; b++) begin
      v[b] = x[(b < VALUE_WIDTH) ? b : VALUE_WIDTH - 1];
    end
    return v;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/deq_cell.sv]
`default_nettype none

module deq_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  deq_pkg::cell_op_t      op,
  input  deq_pkg::value_t        push_value,
  input  deq_pkg::value_t        left_value,
  input  wire logic              left_valid,
  input  deq_pkg::value_t        right_value,
  input  wire logic              right_valid,
  input  deq_pkg::value_t        head_value,
  output deq_pkg::value_t        value,
  output logic                   valid
);

  logic is_tail;
  logic is_free_head;

  // The occupied cells always form a run starting at cell zero.
  assign is_tail      = valid && !right_valid;
  assign is_free_head = !valid && left_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      unique case (op)
        deq_pkg::OP_PUSH_FRONT: valid <= left_valid;
        deq_pkg::OP_PUSH_BACK:  if (is_free_head) valid <= 1'b1;
        deq_pkg::OP_POP_FRONT:  valid <= right_valid;
        deq_pkg::OP_POP_BACK:   if (is_tail) valid <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      deq_pkg::OP_PUSH_FRONT: value <= left_value;
      deq_pkg::OP_PUSH_BACK:  if (is_free_head) value <= push_value;
      deq_pkg::OP_POP_FRONT:  value <= right_value;
      deq_pkg::OP_ROTATE: begin
        if (is_tail) value <= head_value;
        else if (valid) value <= right_value;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/deq_ctrl.sv]
`default_nettype none

module deq_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [2:0]                 req_type,
  input  deq_pkg::value_t                 head_value,
  output logic                            busy,
  output deq_pkg::cell_op_t               op,
  output logic [deq_pkg::CNT_W-1:0]       count,
  output logic                            strobe,
  output logic [1:0]                      status,
  output logic signed [31:0]              entry_value,
  output logic                            last
);

  deq_pkg::state_t state;
  logic [deq_pkg::CNT_W-1:0] idx;
  logic accept;
  logic full;
  logic empty;
  logic dump_last;

  assign busy      = (state == deq_pkg::ST_DUMP);
  assign accept    = start && !busy;
  assign full      = (count == deq_pkg::CNT_W'(deq_pkg::DEPTH));
  assign empty     = (count == '0);
  assign dump_last = ((idx + deq_pkg::CNT_W'(1)) == count);

  always_comb begin
    op = deq_pkg::OP_HOLD;
    if (busy) begin
      op = deq_pkg::OP_ROTATE;
    end else if (accept) begin
      unique case (req_type) inside
        deq_pkg::REQ_PUSH_FRONT: if (!full) op = deq_pkg::OP_PUSH_FRONT;
        deq_pkg::REQ_PUSH_BACK:  if (!full) op = deq_pkg::OP_PUSH_BACK;
        deq_pkg::REQ_POP_FRONT:  if (!empty) op = deq_pkg::OP_POP_FRONT;
        deq_pkg::REQ_POP_BACK:   if (!empty) op = deq_pkg::OP_POP_BACK;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= deq_pkg::ST_IDLE;
      count       <= '0;
      idx         <= '0;
      strobe      <= 1'b0;
      status      <= deq_pkg::STATUS_OK;
      entry_value <= '0;
      last        <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        deq_pkg::ST_IDLE: begin
          if (accept) begin
            status      <= deq_pkg::STATUS_OK;
            entry_value <= '0;
            last        <= 1'b1;
            unique case (req_type) inside
              deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_BACK: begin
                strobe <= 1'b1;
                if (full) status <= deq_pkg::STATUS_FULL;
                else count <= count + deq_pkg::CNT_W'(1);
              end
              deq_pkg::REQ_POP_FRONT, deq_pkg::REQ_POP_BACK: begin
                strobe <= 1'b1;
                if (empty) status <= deq_pkg::STATUS_EMPTY;
                else count <= count - deq_pkg::CNT_W'(1);
              end
              deq_pkg::REQ_DUMP: begin
                if (empty) begin
                  strobe <= 1'b1;
                  status <= deq_pkg::STATUS_EMPTY;
                end else begin
                  state <= deq_pkg::ST_DUMP;
                  idx   <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        deq_pkg::ST_DUMP: begin
          strobe      <= 1'b1;
          status      <= deq_pkg::STATUS_OK;
          entry_value <= deq_pkg::to_port(head_value);
          last        <= dump_last;
          idx         <= idx + deq_pkg::CNT_W'(1);
          if (dump_last) state <= deq_pkg::ST_IDLE;
        end
        default: state <= deq_pkg::ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/double_ended_queue.sv]
`default_nettype none

// Double-ended queue built as a row of cells, front entry in cell zero. A push or pop
// is taken whenever busy is low and answers with one strobed result in the next cycle,
// so such items can follow one per cycle. A dump of a non-empty queue holds busy high
// and streams one entry per cycle, front to back, by rotating the cell row; a dump of
// an empty queue answers with one EMPTY result. Results appear for one cycle only and
// must be captured on strobe, as the receiver cannot stall the block.
module double_ended_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         req_type,
  input  wire logic signed [31:0] push_value,
  output logic                    strobe,
  output logic [1:0]              status,
  output logic signed [31:0]      entry_value,
  output logic                    last
);

  deq_pkg::cell_op_t op;
  deq_pkg::value_t cell_value [deq_pkg::DEPTH];
  logic [deq_pkg::DEPTH-1:0] cell_valid;
  logic [deq_pkg::CNT_W-1:0] count;
  deq_pkg::value_t push_ext;

  assign push_ext = deq_pkg::from_port(push_value);

  deq_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .req_type    (req_type),
    .head_value  (cell_value[0]),
    .busy        (busy),
    .op          (op),
    .count       (count),
    .strobe      (strobe),
    .status      (status),
    .entry_value (entry_value),
    .last        (last)
  );

  for (genvar i = 0; i < deq_pkg::DEPTH; i++) begin : g_cell
    deq_pkg::value_t left_value;
    deq_pkg::value_t right_value;
    logic left_valid;
    logic right_valid;

    if (i == 0) begin : g_first
      assign left_value = push_ext;
      assign left_valid = 1'b1;
    end else begin : g_mid_left
      assign left_value = cell_value[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == deq_pkg::DEPTH - 1) begin : g_last
      assign right_value = '0;
      assign right_valid = 1'b0;
    end else begin : g_mid_right
      assign right_value = cell_value[i+1];
      assign right_valid = cell_valid[i+1];
    end

    deq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .op          (op),
      .push_value  (push_ext),
      .left_value  (left_value),
      .left_valid  (left_valid),
      .right_value (right_value),
      .right_valid (right_valid),
      .head_value  (cell_value[0]),
      .value       (cell_value[i]),
      .valid       (cell_valid[i])
    );
  end

`ifndef SYNTHESIS
  a_count_matches_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(count))
    else $error("Entry count disagrees with occupied cells.");

  a_cells_contiguous: assert property (@(posedge clk) disable iff (rst)
    ((cell_valid + deq_pkg::DEPTH'(1)) & cell_valid) == '0)
    else $error("Occupied cells do not start at the front.");

  a_dump_streams: assert property (@(posedge clk) disable iff (rst)
    busy |=> strobe)
    else $error("A dump cycle gave no item.");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && status != deq_pkg::STATUS_OK) |-> last)
    else $error("An error item was not marked last.");
`endif

endmodule

`default_nettype wire
